FILE: rtl/core/rvx_pkg.sv
// Shared types and encodings for the RV32I instruction executor.
`timescale 1ns / 1ps
package rvx_pkg;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_SHAMT = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    // funct7 codes
    localparam logic [6:0] F7_ZERO = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // ALU funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // Load / store funct3 codes
    localparam logic [2:0] F3_BYTE  = 3'd0;
    localparam logic [2:0] F3_HALF  = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_BYTEU = 3'd4;
    localparam logic [2:0] F3_HALFU = 3'd5;

    // Execute stage result
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] following_pc;
        logic        redirected;
        logic        dest_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic [31:0] store_address;
        logic        is_load;
    } t_exec_res;

    // Data memory request
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [31:0] addr;
        logic [2:0]  f3;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

FILE: rtl/core/rvx_in_if.sv
// Instruction word channel.
`timescale 1ns / 1ps
interface rvx_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source(output valid, output instruction_word, input ready);
    modport sink(input valid, input instruction_word, output ready);
endinterface

FILE: rtl/core/rvx_cfg_if.sv
// Start address write channel.
`timescale 1ns / 1ps
interface rvx_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_address;

    modport source(output valid, output start_address, input ready);
    modport sink(input valid, input start_address, output ready);
endinterface

FILE: rtl/core/rvx_out_if.sv
// Execution result channel.
`timescale 1ns / 1ps
interface rvx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] executed_pc;
    logic [31:0] following_pc;
    logic        redirected;
    logic        dest_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        store_done;
    logic [31:0] store_address;

    modport source(output valid, output status, output executed_pc, output following_pc,
                   output redirected, output dest_written, output dest_index,
                   output dest_value, output store_done, output store_address,
                   input ready);
    modport sink(input valid, input status, input executed_pc, input following_pc,
                 input redirected, input dest_written, input dest_index,
                 input dest_value, input store_done, input store_address,
                 output ready);
endinterface

FILE: rtl/core/rvx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/rvx_exec.sv
// Decode and execute: ALU, branch resolve, address check for one instruction.
`timescale 1ns / 1ps
module rvx_exec #(
    parameter int MEM_BYTES = 4096
) (
    input  logic [31:0]       i_word,
    input  logic [31:0]       i_pc,
    input  logic [31:0]       i_rs1_val,
    input  logic [31:0]       i_rs2_val,
    output rvx_pkg::t_exec_res o_res,
    output rvx_pkg::t_mem_req  o_req
);
    import rvx_pkg::*;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  shamt;
    logic [31:0] a, b;
    logic [31:0] imm_i, imm_s, imm_b, imm_j;
    logic [1:0]  status;
    logic [31:0] nxt, val, addr;
    logic [2:0]  nbytes;
    logic        wr, redir, st, ld, take, addr_ok;

    assign opc   = i_word[6:0];
    assign rd    = i_word[11:7];
    assign f3    = i_word[14:12];
    assign f7    = i_word[31:25];
    assign shamt = i_word[24:20];
    assign a     = i_rs1_val;
    assign b     = i_rs2_val;
    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};

    // Execute
    always_comb begin
        status  = ST_OK;
        nxt     = i_pc + 32'd4;
        val     = '0;
        addr    = '0;
        nbytes  = 3'd0;
        addr_ok = 1'b0;
        wr      = 1'b0;
        redir   = 1'b0;
        st      = 1'b0;
        ld      = 1'b0;
        take    = 1'b0;
        case (opc)
            OPC_LOAD: begin
                addr = a + imm_i;
                case (f3)
                    F3_BYTE, F3_BYTEU: nbytes = 3'd1;
                    F3_HALF, F3_HALFU: nbytes = 3'd2;
                    F3_WORD:           nbytes = 3'd4;
                    default:           nbytes = 3'd0;
                endcase
                // Access stays inside the data memory, no wrap
                addr_ok = ({1'b0, addr} + {30'b0, nbytes}) <= 33'(MEM_BYTES);
                if (nbytes == 3'd0) begin
                    status = ST_UNDEF;
                end else if (!addr_ok) begin
                    status = ST_FAULT;
                end else begin
                    wr = 1'b1;
                    ld = 1'b1;
                end
            end
            OPC_FENCE: begin
                if (f3 != 3'd0) status = ST_UNDEF;
            end
            OPC_OPIMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD:  val = a + imm_i;
                    F3_SLT:  val = {31'b0, $signed(a) < $signed(imm_i)};
                    F3_SLTU: val = {31'b0, a < imm_i};
                    F3_XOR:  val = a ^ imm_i;
                    F3_OR:   val = a | imm_i;
                    F3_AND:  val = a & imm_i;
                    F3_SLL: begin
                        if (i_word[25]) status = ST_SHAMT;
                        else            val = a << shamt;
                    end
                    default: begin
                        if (f7 == F7_ZERO)     val = a >> shamt;
                        else if (f7 == F7_ALT) val = 32'($signed(a) >>> shamt);
                        else                   status = ST_UNDEF;
                    end
                endcase
            end
            OPC_AUIPC: begin
                val = i_pc + {i_word[31:12], 12'b0};
                wr  = 1'b1;
            end
            OPC_STORE: begin
                addr = a + imm_s;
                case (f3)
                    F3_BYTE: nbytes = 3'd1;
                    F3_HALF: nbytes = 3'd2;
                    F3_WORD: nbytes = 3'd4;
                    default: nbytes = 3'd0;
                endcase
                addr_ok = ({1'b0, addr} + {30'b0, nbytes}) <= 33'(MEM_BYTES);
                if (nbytes == 3'd0)  status = ST_UNDEF;
                else if (!addr_ok)   status = ST_FAULT;
                else                 st = 1'b1;
            end
            OPC_OP: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_ZERO)     val = a + b;
                        else if (f7 == F7_ALT) val = a - b;
                        else                   status = ST_UNDEF;
                    end
                    F3_SLL:  val = a << b[4:0];
                    F3_SLT:  val = {31'b0, $signed(a) < $signed(b)};
                    F3_SLTU: val = {31'b0, a < b};
                    F3_XOR:  val = a ^ b;
                    F3_SR: begin
                        if (f7 == F7_ZERO)     val = a >> b[4:0];
                        else if (f7 == F7_ALT) val = 32'($signed(a) >>> b[4:0]);
                        else                   status = ST_UNDEF;
                    end
                    F3_OR:   val = a | b;
                    default: val = a & b;
                endcase
            end
            OPC_LUI: begin
                val = {i_word[31:12], 12'b0};
                wr  = 1'b1;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = $signed(a) < $signed(b);
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: status = ST_UNDEF;
                endcase
                if (take) begin
                    nxt   = i_pc + imm_b;
                    redir = 1'b1;
                end
            end
            OPC_JALR: begin
                nxt   = (a + imm_i) & ~32'd1;
                val   = i_pc + 32'd4;
                wr    = 1'b1;
                redir = 1'b1;
            end
            OPC_JAL: begin
                nxt   = i_pc + imm_j;
                val   = i_pc + 32'd4;
                wr    = 1'b1;
                redir = 1'b1;
            end
            OPC_SYSTEM: begin
                if (f3 != 3'd0 || i_word[31:20] > 12'd1) status = ST_UNDEF;
            end
            default: status = ST_UNDEF;
        endcase

        // Drop all side effects of a failing instruction
        if (status != ST_OK) begin
            nxt   = i_pc;
            wr    = 1'b0;
            redir = 1'b0;
            st    = 1'b0;
            ld    = 1'b0;
        end
        if (rd == 5'd0) wr = 1'b0;
    end

    // Pack results
    always_comb begin
        o_res.status        = status;
        o_res.following_pc  = nxt;
        o_res.redirected    = redir;
        o_res.dest_written  = wr;
        o_res.dest_index    = wr ? rd : 5'd0;
        o_res.dest_value    = (wr && !ld) ? val : 32'd0;
        o_res.store_done    = st;
        o_res.store_address = st ? addr : 32'd0;
        o_res.is_load       = ld;
        o_req.rd            = ld;
        o_req.wr            = st;
        o_req.addr          = addr;
        o_req.f3            = f3;
        o_req.wdata         = b;
    end
endmodule

FILE: rtl/core/rvx_dmem.sv
// Data memory: four byte banks, reset clearing sweep, load word assembly.
`timescale 1ns / 1ps
module rvx_dmem #(
    parameter int MEM_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_req_valid,
    input  rvx_pkg::t_mem_req i_req,
    output logic              o_clearing,
    output logic [31:0]       o_load_value
);
    import rvx_pkg::*;

    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [RW-1:0] r_clr_row;
    logic          r_clearing;
    logic [1:0]    r_lo;
    logic [2:0]    r_f3;
    logic [2:0]    nbytes;
    logic [7:0]    bank_rdata [4];
    logic [7:0]    by0, by1, by2, by3;

    // Sweep every row to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + RW'(1);
            if (r_clr_row == RW'(ROWS - 1)) r_clearing <= 1'b0;
        end
    end

    assign o_clearing = r_clearing;

    // Access size in bytes
    always_comb begin
        case (i_req.f3[1:0])
            2'd0:    nbytes = 3'd1;
            2'd1:    nbytes = 3'd2;
            default: nbytes = 3'd4;
        endcase
    end

    // One bank per byte lane
    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [1:0]    off;
        logic [31:0]   byte_addr;
        logic          en;
        logic          we;
        logic [RW-1:0] row;
        logic [RW-1:0] waddr;
        logic [7:0]    wdata;

        always_comb begin
            off       = 2'(j) - i_req.addr[1:0];
            byte_addr = i_req.addr + {30'b0, off};
            row       = byte_addr[RW+1:2];
            en        = {1'b0, off} < nbytes;
            we        = r_clearing || (i_adv && i_req_valid && i_req.wr && en);
            waddr     = r_clearing ? r_clr_row : row;
            wdata     = r_clearing ? 8'd0 : 8'(i_req.wdata >> {off, 3'b000});
        end

        rvx_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .i_clk  (i_clk),
            .i_we   (we),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_re   (i_adv),
            .i_raddr(row),
            .o_rdata(bank_rdata[j])
        );
    end

    // Hold the lane offset and size alongside the read data
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lo <= i_req.addr[1:0];
            r_f3 <= i_req.f3;
        end
    end

    // Rotate lanes back into byte order and extend
    assign by0 = bank_rdata[r_lo];
    assign by1 = bank_rdata[r_lo + 2'd1];
    assign by2 = bank_rdata[r_lo + 2'd2];
    assign by3 = bank_rdata[r_lo + 2'd3];

    always_comb begin
        case (r_f3)
            F3_BYTE:  o_load_value = {{24{by0[7]}}, by0};
            F3_BYTEU: o_load_value = {24'b0, by0};
            F3_HALF:  o_load_value = {{16{by1[7]}}, by1, by0};
            F3_HALFU: o_load_value = {16'b0, by1, by0};
            default:  o_load_value = {by3, by2, by1, by0};
        endcase
    end
endmodule

FILE: rtl/core/rv32i_instruction_executor.sv
// RV32I instruction executor: pipeline registers, register file, forwarding.
//
// Usage: each word on i_instr is one RV32I instruction, executed at the
// current pc against 32 integer registers and MEM_BYTES of little-endian
// data memory. Every instruction yields one word on o_result with status,
// pc before and after, register write and store report. i_cfg writes the
// start address and loads the pc at once; write it only while idle.
// Pipeline: input register with register file read, execute, memory data,
// output register. The result passes through the input, memory data and
// output registers; one instruction per cycle is sustained while o_result
// is not stalled, limited by the single pass through the execute stage
// (results forwarded, no hazard bubbles). Reset clears the registers and
// the pc, then sweeps the data memory one four-byte row a cycle, during
// which i_instr.ready stays low; i_cfg is taken throughout.
// When o_result is stalled, the whole pipeline holds and i_instr.ready
// drops; no word is lost or repeated.
`timescale 1ns / 1ps
module rv32i_instruction_executor #(
    parameter int MEM_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rvx_cfg_if.sink    i_cfg,
    rvx_in_if.sink     i_instr,
    rvx_out_if.source  o_result
);
    import rvx_pkg::*;

    logic        adv, accept, clearing;
    logic [31:0] r_pc, fetch_pc;
    logic [31:0] r_rf_valid;
    logic        r_a_valid;
    logic [31:0] r_a_word, r_a_pc;
    logic [31:0] rf_rdata1, rf_rdata2, rs1_val, rs2_val;
    logic [4:0]  a_rs1, a_rs2;
    t_exec_res   a_res;
    t_mem_req    a_req;
    logic        r_b_valid;
    t_exec_res   r_b_res;
    t_exec_res   b_res_out;
    logic [31:0] r_b_pc, b_value, load_value;
    logic        b_wr;
    logic        r_o_valid;
    t_exec_res   r_o_res;
    logic [31:0] r_o_pc;

    // Global advance: output register free or being taken
    assign adv            = !r_o_valid || o_result.ready;
    assign i_instr.ready  = adv && !clearing;
    assign accept         = i_instr.valid && i_instr.ready;
    assign i_cfg.ready    = 1'b1;
    assign fetch_pc       = r_a_valid ? a_res.following_pc : r_pc;

    // Register file, two read ports as two copies
    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk  (i_clk),
        .i_we   (adv && b_wr),
        .i_waddr(r_b_res.dest_index),
        .i_wdata(b_value),
        .i_re   (adv),
        .i_raddr(i_instr.instruction_word[19:15]),
        .o_rdata(rf_rdata1)
    );

    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk  (i_clk),
        .i_we   (adv && b_wr),
        .i_waddr(r_b_res.dest_index),
        .i_wdata(b_value),
        .i_re   (adv),
        .i_raddr(i_instr.instruction_word[24:20]),
        .o_rdata(rf_rdata2)
    );

    // Mark registers written since reset; unwritten ones read zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
        end else if (adv && b_wr) begin
            r_rf_valid[r_b_res.dest_index] <= 1'b1;
        end
    end

    // Forward from memory stage, then output stage, then file
    assign a_rs1 = r_a_word[19:15];
    assign a_rs2 = r_a_word[24:20];
    assign b_wr  = r_b_valid && r_b_res.dest_written;

    always_comb begin
        if (b_wr && r_b_res.dest_index == a_rs1)
            rs1_val = b_value;
        else if (r_o_valid && r_o_res.dest_written && r_o_res.dest_index == a_rs1)
            rs1_val = r_o_res.dest_value;
        else
            rs1_val = r_rf_valid[a_rs1] ? rf_rdata1 : 32'd0;
        if (b_wr && r_b_res.dest_index == a_rs2)
            rs2_val = b_value;
        else if (r_o_valid && r_o_res.dest_written && r_o_res.dest_index == a_rs2)
            rs2_val = r_o_res.dest_value;
        else
            rs2_val = r_rf_valid[a_rs2] ? rf_rdata2 : 32'd0;
    end

    rvx_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
        .i_word   (r_a_word),
        .i_pc     (r_a_pc),
        .i_rs1_val(rs1_val),
        .i_rs2_val(rs2_val),
        .o_res    (a_res),
        .o_req    (a_req)
    );

    rvx_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_req_valid (r_a_valid),
        .i_req       (a_req),
        .o_clearing  (clearing),
        .o_load_value(load_value)
    );

    assign b_value = r_b_res.is_load ? load_value : r_b_res.dest_value;

    // Merge the load data into the memory stage result
    always_comb begin
        b_res_out            = r_b_res;
        b_res_out.dest_value = r_b_res.dest_written ? b_value : 32'd0;
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_pc <= i_cfg.start_address;
            end else if (adv) begin
                r_pc <= fetch_pc;
            end
            if (adv) begin
                r_a_valid <= accept;
                r_b_valid <= r_a_valid;
                r_o_valid <= r_b_valid;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_word <= i_instr.instruction_word;
            r_a_pc   <= fetch_pc;
            r_b_res  <= a_res;
            r_b_pc   <= r_a_pc;
            r_o_res  <= b_res_out;
            r_o_pc   <= r_b_pc;
        end
    end

    // Drive the result word
    assign o_result.valid         = r_o_valid;
    assign o_result.status        = r_o_res.status;
    assign o_result.executed_pc   = r_o_pc;
    assign o_result.following_pc  = r_o_res.following_pc;
    assign o_result.redirected    = r_o_res.redirected;
    assign o_result.dest_written  = r_o_res.dest_written;
    assign o_result.dest_index    = r_o_res.dest_index;
    assign o_result.dest_value    = r_o_res.dest_value;
    assign o_result.store_done    = r_o_res.store_done;
    assign o_result.store_address = r_o_res.store_address;

    // Checks
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_res.status != ST_OK) |->
        (!r_o_res.dest_written && !r_o_res.store_done && !r_o_res.redirected &&
         r_o_res.following_pc == r_o_pc))
        else $error("failing instruction left side effects");

    a_no_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_res.dest_written) |-> (r_o_res.dest_index != 5'd0))
        else $error("write to x0 reported");

    a_seq_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_res.status == ST_OK && !r_o_res.redirected) |->
        (r_o_res.following_pc == r_o_pc + 32'd4))
        else $error("sequential pc mismatch");

    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !i_instr.ready)
        else $error("instruction taken during memory clear");

    a_no_rf_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> !r_rf_valid[0])
        else $error("x0 marked written");
endmodule

FILE: verif/testbench.sv
// Testbench for the RV32I instruction executor: directed and random programs, checked per word.
`timescale 1ns / 1ps
module testbench;
    import rvx_pkg::*;

    localparam int MEM_SIZE = 4096;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] executed_pc;
        logic [31:0] following_pc;
        logic        redirected;
        logic        dest_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic [31:0] store_address;
    } retire_t;

    logic i_clk;
    logic i_rst_n;

    rvx_cfg_if cfg_ch();
    rvx_in_if  instr_ch();
    rvx_out_if result_ch();

    rv32i_instruction_executor #(.MEM_BYTES(MEM_SIZE)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_instr (instr_ch.sink),
        .o_result(result_ch.source)
    );

    // Architectural shadow state
    logic [31:0] arch_regs [32];
    logic [31:0] arch_pc;
    logic [7:0]  arch_mem [MEM_SIZE];
    retire_t     pending_retires[$];
    int          fail_count = 0;
    bit          quiet_phase = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up after a generous time
    initial begin
        #50ms;
        $display("rv32i_instruction_executor test failed");
        $finish;
    end

    // Instruction encoders
    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic bit mem_fits(logic [31:0] addr, int n);
        return ({32'b0, addr} + 64'(n)) <= 64'(MEM_SIZE);
    endfunction

    // Execute one instruction on the shadow state and return its retire report
    task automatic execute_word(input logic [31:0] w, output retire_t r);
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, val, addr, next;
        logic [4:0]  shamt;
        int          n;
        bit          wr, redir, st, take;
        opc   = w[6:0];
        rd    = w[11:7];
        f3    = w[14:12];
        f7    = w[31:25];
        a     = arch_regs[w[19:15]];
        b     = arch_regs[w[24:20]];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        shamt = w[24:20];
        r.status = ST_OK;
        next = arch_pc + 32'd4;
        val = '0; addr = '0; n = 0;
        wr = 0; redir = 0; st = 0; take = 0;
        case (opc)
            OPC_LOAD: begin
                addr = a + imm_i;
                case (f3)
                    F3_BYTE, F3_BYTEU: n = 1;
                    F3_HALF, F3_HALFU: n = 2;
                    F3_WORD:           n = 4;
                    default:           n = 0;
                endcase
                if (n == 0) r.status = ST_UNDEF;
                else if (!mem_fits(addr, n)) r.status = ST_FAULT;
                else begin
                    for (int i = 0; i < n; i++) val[8*i +: 8] = arch_mem[addr + i];
                    if (f3 == F3_BYTE) val = {{24{val[7]}}, val[7:0]};
                    if (f3 == F3_HALF) val = {{16{val[15]}}, val[15:0]};
                    wr = 1;
                end
            end
            OPC_FENCE: if (f3 != 3'd0) r.status = ST_UNDEF;
            OPC_OPIMM: begin
                wr = 1;
                case (f3)
                    F3_ADD:  val = a + imm_i;
                    F3_SLT:  val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
                    F3_SLTU: val = (a < imm_i) ? 32'd1 : 32'd0;
                    F3_XOR:  val = a ^ imm_i;
                    F3_OR:   val = a | imm_i;
                    F3_AND:  val = a & imm_i;
                    F3_SLL:  if (w[25]) r.status = ST_SHAMT; else val = a << shamt;
                    default: begin
                        if (f7 == F7_ZERO) val = a >> shamt;
                        else if (f7 == F7_ALT) val = $signed(a) >>> shamt;
                        else r.status = ST_UNDEF;
                    end
                endcase
            end
            OPC_AUIPC: begin
                val = arch_pc + {w[31:12], 12'b0};
                wr = 1;
            end
            OPC_STORE: begin
                addr = a + imm_s;
                n = (f3 <= F3_WORD) ? (1 << f3) : 0;
                if (n == 0) r.status = ST_UNDEF;
                else if (!mem_fits(addr, n)) r.status = ST_FAULT;
                else begin
                    for (int i = 0; i < n; i++) arch_mem[addr + i] = b[8*i +: 8];
                    st = 1;
                end
            end
            OPC_OP: begin
                wr = 1;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_ZERO) val = a + b;
                        else if (f7 == F7_ALT) val = a - b;
                        else r.status = ST_UNDEF;
                    end
                    F3_SLL:  val = a << b[4:0];
                    F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
                    F3_XOR:  val = a ^ b;
                    F3_SR: begin
                        if (f7 == F7_ZERO) val = a >> b[4:0];
                        else if (f7 == F7_ALT) val = $signed(a) >>> b[4:0];
                        else r.status = ST_UNDEF;
                    end
                    F3_OR:   val = a | b;
                    default: val = a & b;
                endcase
            end
            OPC_LUI: begin
                val = {w[31:12], 12'b0};
                wr = 1;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: r.status = ST_UNDEF;
                endcase
                if (take) begin
                    next = arch_pc + imm_b;
                    redir = 1;
                end
            end
            OPC_JALR: begin
                next = (a + imm_i) & ~32'd1;
                val = arch_pc + 32'd4;
                wr = 1;
                redir = 1;
            end
            OPC_JAL: begin
                next = arch_pc + imm_j;
                val = arch_pc + 32'd4;
                wr = 1;
                redir = 1;
            end
            OPC_SYSTEM: if (f3 != 3'd0 || w[31:20] > 12'd1) r.status = ST_UNDEF;
            default: r.status = ST_UNDEF;
        endcase
        // A failing word changes nothing
        if (r.status != ST_OK) begin
            next = arch_pc;
            wr = 0; redir = 0; st = 0;
        end
        if (rd == 5'd0) wr = 0;
        if (wr) arch_regs[rd] = val;
        r.executed_pc   = arch_pc;
        r.following_pc  = next;
        r.redirected    = redir;
        r.dest_written  = wr;
        r.dest_index    = wr ? rd : 5'd0;
        r.dest_value    = wr ? val : 32'd0;
        r.store_done    = st;
        r.store_address = st ? addr : 32'd0;
        arch_pc = next;
    endtask

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int p;
        if (quiet_phase) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one instruction word and record what it must retire
    task automatic send_word(input logic [31:0] w);
        int gap;
        retire_t r;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            instr_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        instr_ch.valid <= 1'b1;
        instr_ch.instruction_word <= w;
        do @(posedge i_clk); while (!instr_ch.ready);
        execute_word(w, r);
        pending_retires.push_back(r);
    endtask

    // Let the pipeline empty out
    task automatic drain();
        int guard;
        @(negedge i_clk);
        instr_ch.valid <= 1'b0;
        guard = 0;
        while (pending_retires.size() != 0) begin
            @(posedge i_clk);
            guard++;
            if (guard > 100000) begin
                $display("rv32i_instruction_executor test failed");
                $finish;
            end
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the start address while idle; the pc reloads with it
    task automatic set_start(input logic [31:0] value);
        drain();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.start_address <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        arch_pc = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result sink stalls
    initial begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0 && !quiet_phase) begin
                result_ch.ready <= 1'b0;
                stall--;
            end else begin
                result_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Compare each retired word against the oldest prediction
    always @(posedge i_clk) begin
        retire_t e;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_retires.size() == 0) begin
                $error("result word with nothing pending");
                fail_count++;
            end else begin
                e = pending_retires.pop_front();
                cmp("status",        32'(e.status),       32'(result_ch.status));
                cmp("executed_pc",   e.executed_pc,       result_ch.executed_pc);
                cmp("following_pc",  e.following_pc,      result_ch.following_pc);
                cmp("redirected",    32'(e.redirected),   32'(result_ch.redirected));
                cmp("dest_written",  32'(e.dest_written), 32'(result_ch.dest_written));
                cmp("dest_index",    32'(e.dest_index),   32'(result_ch.dest_index));
                cmp("dest_value",    e.dest_value,        result_ch.dest_value);
                cmp("store_done",    32'(e.store_done),   32'(result_ch.store_done));
                cmp("store_address", e.store_address,     result_ch.store_address);
            end
        end
    end

    // Random but mostly well-formed instruction
    function automatic logic [31:0] random_word();
        int p;
        logic [4:0] rd, rs1, rs2, base;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [11:0] imm;
        rd  = $urandom_range(0, 31);
        rs1 = $urandom_range(0, 31);
        rs2 = $urandom_range(0, 31);
        f3  = $urandom_range(0, 7);
        imm = $urandom;
        p = $urandom_range(0, 2);
        base = (p == 0) ? 5'd0 : (p == 1) ? 5'd31 : rs1;
        if (base == 5'd0) imm = $urandom_range(0, 2047);
        p = $urandom_range(0, 3);
        f7 = (p == 0) ? F7_ZERO : (p == 1) ? F7_ALT : (p == 2) ? 7'($urandom) : F7_ZERO;
        p = $urandom_range(0, 99);
        if (p < 14) return enc_i(imm, base, f3, rd == 5'd31 ? 5'd30 : rd, OPC_LOAD);
        if (p < 26) return enc_s(imm, rs2, base, f3 & 3'd3);
        if (p < 42) begin
            if (f3 == F3_SLL || f3 == F3_SR) imm = {f7, imm[4:0]};
            return enc_i(imm, rs1, f3, rd, OPC_OPIMM);
        end
        if (p < 58) return enc_r(f7, rs2, rs1, f3, rd);
        if (p < 62) return {20'($urandom), rd, OPC_LUI};
        if (p < 65) return {20'($urandom), rd, OPC_AUIPC};
        if (p < 77) return enc_b(13'($urandom), rs2, rs1, f3);
        if (p < 81) return enc_j(21'($urandom), rd);
        if (p < 85) return enc_i(imm, rs1, f3, rd, OPC_JALR);
        if (p < 88) return enc_i(imm, rs1, $urandom_range(0, 3) == 0 ? f3 : 3'd0, rd, OPC_FENCE);
        if (p < 92) return enc_i(12'($urandom_range(0, 2)), rs1, $urandom_range(0, 3) == 0 ?
                                 f3 : 3'd0, rd, OPC_SYSTEM);
        return $urandom;
    endfunction

    // Extremes, a selection of operations and corner cases
    task automatic test_directed();
        send_word(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd31, OPC_OPIMM));  // x31 = 2047
        send_word(enc_i(12'h800, 5'd0, F3_ADD, 5'd1, OPC_OPIMM));   // x1 = -2048
        send_word({20'hFFFFF, 5'd2, OPC_LUI});                     // x2 = 0xFFFFF000
        send_word(enc_i(12'd5, 5'd0, F3_ADD, 5'd0, OPC_OPIMM));     // write to x0 dropped
        send_word(enc_s(12'd1, 5'd1, 5'd31, F3_WORD));              // sw at 2048
        send_word(enc_i(12'd1, 5'd31, F3_HALF, 5'd3, OPC_LOAD));    // lh 2048
        send_word(enc_i(12'd2, 5'd31, F3_BYTEU, 5'd4, OPC_LOAD));   // lbu
        send_word(enc_i(12'h7FD, 5'd31, F3_WORD, 5'd5, OPC_LOAD));  // lw at 4092 ok
        send_word(enc_i(12'h7FE, 5'd31, F3_WORD, 5'd5, OPC_LOAD));  // lw at 4093 faults
        send_word(enc_s(12'h000, 5'd1, 5'd1, F3_BYTE));             // negative address faults
        send_word(enc_i(12'd3, 5'd0, F3_WORD + 3'd1, 5'd6, OPC_LOAD)); // undefined load size
        send_word(enc_s(12'd3, 5'd1, 5'd0, 3'd3));                  // undefined store size
        send_word(enc_i({7'b0000001, 5'd4}, 5'd1, F3_SLL, 5'd7, OPC_OPIMM)); // bad shamt
        send_word(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd8, OPC_OPIMM)); // srai 31
        send_word(enc_i({7'b0000001, 5'd1}, 5'd1, F3_SR, 5'd8, OPC_OPIMM)); // bad funct7
        send_word(enc_i(12'hFFF, 5'd1, F3_SLT, 5'd9, OPC_OPIMM));   // slti signed
        send_word(enc_r(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd10));        // sub
        send_word(enc_r(F7_ALT, 5'd31, 5'd2, F3_SR, 5'd11));        // sra, rs2 low 5 bits
        send_word(enc_b(13'h1FFC, 5'd0, 5'd0, F3_BEQ));             // taken backward
        send_word(enc_b(13'd8, 5'd0, 5'd0, 3'd2));                  // undefined branch
        send_word(enc_j(21'h0FFFFE, 5'd12));                        // jal max forward
        send_word(enc_i(12'd3, 5'd31, 3'd5, 5'd13, OPC_JALR));      // jalr to x31 + 3
        send_word(enc_i(12'd0, 5'd0, 3'd1, 5'd0, OPC_FENCE));       // undefined fence
        send_word(enc_i(12'd2, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));      // undefined system
        send_word(32'hFFFF_FFFE);                                  // low opcode bits not 11
        send_word(32'h0000_0000);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) send_word(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd31, OPC_OPIMM));
            else send_word(random_word());
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.start_address = '0;
        instr_ch.valid = 1'b0;
        instr_ch.instruction_word = '0;
        arch_pc = '0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        set_start(32'hFFFF_FFFF);
        test_random(390);
        set_start(32'h0000_0000);
        quiet_phase = 1;
        test_random(390);
        quiet_phase = 0;
        set_start($urandom);
        test_random(390);
        set_start(32'h8000_0000);
        test_random(390);
        set_start($urandom);
        test_random(390);
        drain();

        if (fail_count == 0) $display("rv32i_instruction_executor test passed");
        else $display("rv32i_instruction_executor test failed");
        $finish;
    end
endmodule
